// File: hdl/lcdst_pkg.sv
// Package for the LCD scanline timing and register block.
// Holds item types, request and mode codes, register addresses and timing constants.
// No dependencies.
`default_nettype none

package lcdst_pkg;

  // Request codes carried by one input item
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2
  } req_t;

  // LCD mode codes, as seen in the status register
  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_DRAW   = 2'd3
  } mode_t;

  // Register addresses, low byte of the 0xFF00 page
  localparam logic [7:0] ADDR_CTRL  = 8'h40;
  localparam logic [7:0] ADDR_STAT  = 8'h41;
  localparam logic [7:0] ADDR_SCY   = 8'h42;
  localparam logic [7:0] ADDR_SCX   = 8'h43;
  localparam logic [7:0] ADDR_LINE  = 8'h44;
  localparam logic [7:0] ADDR_CMP   = 8'h45;
  localparam logic [7:0] ADDR_DMA   = 8'h46;
  localparam logic [7:0] ADDR_PAL0  = 8'h47;
  localparam logic [7:0] ADDR_PAL1  = 8'h48;
  localparam logic [7:0] ADDR_PAL2  = 8'h49;
  localparam logic [7:0] ADDR_WIN0  = 8'h4A;
  localparam logic [7:0] ADDR_WIN1  = 8'h4B;

  localparam logic [8:0] DOTS_PER_LINE  = 9'd456;
  localparam logic [7:0] LAST_LINE      = 8'd153;
  localparam logic [7:0] VBLANK_LINE    = 8'd144;
  localparam logic [8:0] SCAN_DOTS      = 9'd80;
  localparam logic [6:0] WARMUP_DOTS    = 7'd80;
  localparam logic [2:0] SHORTEN_AMOUNT = 3'd4;
  localparam int unsigned SEL_LINE_BIT  = 3;   // status select bit for line compare
  localparam int unsigned CTRL_ON_BIT   = 7;   // display enable bit in control
  localparam logic [7:0] UNMAPPED_DATA  = 8'hFF;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       draw_done;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] lcd_mode;
    logic [7:0] current_line;
    logic       vblank_irq;
    logic       stat_irq;
    logic       frame_done;
  } out_item_t;

endpackage

`default_nettype wire

// File: hdl/lcdst_if.sv
// Channel interfaces for the LCD scanline timing and register block.
// Input item channel and result item channel; no package dependency.
`default_nettype none

interface lcdst_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] reg_addr;
  logic [7:0] write_data;
  logic       draw_done;

  modport source (output valid, output req_type, output reg_addr, output write_data,
                  output draw_done, input ready);
  modport sink   (input valid, input req_type, input reg_addr, input write_data,
                  input draw_done, output ready);
endinterface

interface lcdst_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [1:0] lcd_mode;
  logic [7:0] current_line;
  logic       vblank_irq;
  logic       stat_irq;
  logic       frame_done;

  modport source (output valid, output read_data, output lcd_mode, output current_line,
                  output vblank_irq, output stat_irq, output frame_done, input ready);
  modport sink   (input valid, input read_data, input lcd_mode, input current_line,
                  input vblank_irq, input stat_irq, input frame_done, output ready);
endinterface

`default_nettype wire

// File: hdl/lcdst_core.sv
// State and step logic of the LCD scanline timing and register block.
// Holds dot/line/mode timing and the register file; uses lcdst_pkg.
`default_nettype none

module lcdst_core (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        step,
  input  wire lcdst_pkg::in_item_t   item,
  output lcdst_pkg::out_item_t       res
);
  import lcdst_pkg::*;

  logic [8:0] dot_r,    dot_nxt;
  logic [7:0] line_r,   line_nxt;
  mode_t      mode_r,   mode_nxt;
  logic [7:0] ctrl_r,   ctrl_nxt;
  logic [4:0] sel_r,    sel_nxt;
  logic       coinc_r,  coinc_nxt;
  logic [7:0] scy_r,    scy_nxt;
  logic [7:0] scx_r,    scx_nxt;
  logic [7:0] cmp_r,    cmp_nxt;
  logic [7:0] dma_r,    dma_nxt;
  logic [7:0] pal_r [3];
  logic [7:0] pal_nxt [3];
  logic [7:0] win_r [2];
  logic [7:0] win_nxt [2];
  logic       off_r,    off_nxt;
  logic       warm_r,   warm_nxt;
  logic [6:0] wcnt_r,   wcnt_nxt;
  logic [2:0] short_r,  short_nxt;

  logic [7:0] rd;
  logic       vbl, sirq, frm;
  logic [8:0] dot_inc;
  logic [6:0] wcnt_inc;
  logic [8:0] hb_end;
  logic       was_on, now_on;

  always_comb begin
    dot_nxt   = dot_r;
    line_nxt  = line_r;
    mode_nxt  = mode_r;
    ctrl_nxt  = ctrl_r;
    sel_nxt   = sel_r;
    coinc_nxt = coinc_r;
    scy_nxt   = scy_r;
    scx_nxt   = scx_r;
    cmp_nxt   = cmp_r;
    dma_nxt   = dma_r;
    pal_nxt   = pal_r;
    win_nxt   = win_r;
    off_nxt   = off_r;
    warm_nxt  = warm_r;
    wcnt_nxt  = wcnt_r;
    short_nxt = short_r;
    rd   = UNMAPPED_DATA;
    vbl  = 1'b0;
    sirq = 1'b0;
    frm  = 1'b0;
    dot_inc  = dot_r + 9'd1;
    wcnt_inc = wcnt_r + 7'd1;
    hb_end   = DOTS_PER_LINE - {6'd0, short_r};
    was_on   = ctrl_r[CTRL_ON_BIT];
    now_on   = item.write_data[CTRL_ON_BIT];

    case (item.req_type)
      REQ_TICK: begin
        if (!off_r) begin
          dot_nxt = dot_inc;
          if (warm_r) begin
            wcnt_nxt = wcnt_inc;
            if (wcnt_inc == WARMUP_DOTS) begin
              warm_nxt  = 1'b0;
              mode_nxt  = MODE_DRAW;
              short_nxt = SHORTEN_AMOUNT;
            end
          end else begin
            case (mode_r)
              MODE_VBLANK: begin
                if (dot_inc == DOTS_PER_LINE) begin
                  dot_nxt = '0;
                  if (line_r >= LAST_LINE) begin
                    line_nxt = '0;
                    mode_nxt = MODE_OAM;
                    frm      = 1'b1;
                  end else begin
                    line_nxt  = line_r + 8'd1;
                    coinc_nxt = (cmp_r == line_nxt);
                    sirq      = coinc_nxt & sel_r[SEL_LINE_BIT];
                  end
                end
              end
              MODE_OAM: begin
                if (dot_inc == SCAN_DOTS) mode_nxt = MODE_DRAW;
              end
              MODE_DRAW: begin
                if (item.draw_done) mode_nxt = MODE_HBLANK;
              end
              default: begin
                if (dot_inc == hb_end) begin
                  short_nxt = '0;
                  dot_nxt   = '0;
                  line_nxt  = line_r + 8'd1;
                  coinc_nxt = (cmp_r == line_nxt);
                  sirq      = coinc_nxt & sel_r[SEL_LINE_BIT];
                  if (line_nxt == VBLANK_LINE) begin
                    mode_nxt = MODE_VBLANK;
                    vbl      = 1'b1;
                  end else begin
                    mode_nxt = MODE_OAM;
                  end
                end
              end
            endcase
          end
        end
      end
      REQ_READ: begin
        case (item.reg_addr)
          ADDR_CTRL: rd = ctrl_r;
          ADDR_STAT: rd = {sel_r, coinc_r, mode_r};
          ADDR_SCY:  rd = scy_r;
          ADDR_SCX:  rd = scx_r;
          ADDR_LINE: rd = line_r;
          ADDR_CMP:  rd = cmp_r;
          ADDR_DMA:  rd = dma_r;
          ADDR_PAL0: rd = pal_r[0];
          ADDR_PAL1: rd = pal_r[1];
          ADDR_PAL2: rd = pal_r[2];
          ADDR_WIN0: rd = win_r[0];
          ADDR_WIN1: rd = win_r[1];
          default:   rd = UNMAPPED_DATA;
        endcase
      end
      REQ_WRITE: begin
        case (item.reg_addr)
          ADDR_CTRL: begin
            // enable edge restarts the warm-up; disable edge clears the line and dot counters
            if (!was_on && now_on) begin
              warm_nxt = 1'b1;
              off_nxt  = 1'b0;
              wcnt_nxt = '0;
              mode_nxt = MODE_HBLANK;
            end
            if (was_on && !now_on) begin
              off_nxt  = 1'b1;
              line_nxt = '0;
              dot_nxt  = '0;
            end
            ctrl_nxt = item.write_data;
          end
          ADDR_STAT: sel_nxt = item.write_data[7:3];
          ADDR_SCY:  scy_nxt = item.write_data;
          ADDR_SCX:  scx_nxt = item.write_data;
          ADDR_CMP: begin
            cmp_nxt   = item.write_data;
            coinc_nxt = (item.write_data == line_r);
            sirq      = coinc_nxt & sel_r[SEL_LINE_BIT];
          end
          ADDR_DMA:  dma_nxt    = item.write_data;
          ADDR_PAL0: pal_nxt[0] = item.write_data;
          ADDR_PAL1: pal_nxt[1] = item.write_data;
          ADDR_PAL2: pal_nxt[2] = item.write_data;
          ADDR_WIN0: win_nxt[0] = item.write_data;
          ADDR_WIN1: win_nxt[1] = item.write_data;
          default: ;
        endcase
      end
      default: ;
    endcase

    res.read_data    = rd;
    res.lcd_mode     = mode_nxt;
    res.current_line = line_nxt;
    res.vblank_irq   = vbl;
    res.stat_irq     = sirq;
    res.frame_done   = frm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r   <= '0;
      line_r  <= '0;
      mode_r  <= MODE_HBLANK;
      ctrl_r  <= '0;
      sel_r   <= '0;
      coinc_r <= 1'b0;
      scy_r   <= '0;
      scx_r   <= '0;
      cmp_r   <= '0;
      dma_r   <= '0;
      pal_r   <= '{default: '0};
      win_r   <= '{default: '0};
      off_r   <= 1'b1;
      warm_r  <= 1'b0;
      wcnt_r  <= '0;
      short_r <= '0;
    end else if (step) begin
      dot_r   <= dot_nxt;
      line_r  <= line_nxt;
      mode_r  <= mode_nxt;
      ctrl_r  <= ctrl_nxt;
      sel_r   <= sel_nxt;
      coinc_r <= coinc_nxt;
      scy_r   <= scy_nxt;
      scx_r   <= scx_nxt;
      cmp_r   <= cmp_nxt;
      dma_r   <= dma_nxt;
      pal_r   <= pal_nxt;
      win_r   <= win_nxt;
      off_r   <= off_nxt;
      warm_r  <= warm_nxt;
      wcnt_r  <= wcnt_nxt;
      short_r <= short_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/lcd_scanline_timing_registers_unit.sv
// LCD scanline timing and register block: top level with input and result registers.
// Uses lcdst_pkg, lcdst_in_if, lcdst_out_if and lcdst_core.
//
// Each input item is one dot tick, one register read or one register write on the
// 0xFF00 register page; each item yields exactly one result item carrying the read
// data (0xFF for anything but a mapped read), the mode and line after the step, and
// the vblank, line-compare and frame-end pulses. The block takes one item per clock
// when the result side keeps up: an item is captured in the input register, is
// stepped against the timing state by one pass of logic, and lands in the result
// register. A stalled result register holds its item while the input register
// still fills, and ready drops only when both are full.
`default_nettype none

module lcd_scanline_timing_registers_unit (
  input  wire          clk,
  input  wire          rst_n,
  lcdst_in_if.sink     in_ch,
  lcdst_out_if.source  out_ch
);
  import lcdst_pkg::*;

  logic      in_vld_r;
  in_item_t  in_item_r;
  logic      out_vld_r;
  out_item_t out_item_r;
  out_item_t step_res;
  logic      adv;
  logic      step;
  logic      in_rdy;

  // Advance the result register when it is empty or being taken
  assign adv    = !out_vld_r || out_ch.ready;
  assign step   = in_vld_r && adv;
  assign in_rdy = !in_vld_r || adv;
  assign in_ch.ready = in_rdy;

  // Capture the incoming item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_rdy) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_ch.valid) begin
      in_item_r.req_type   <= in_ch.req_type;
      in_item_r.reg_addr   <= in_ch.reg_addr;
      in_item_r.write_data <= in_ch.write_data;
      in_item_r.draw_done  <= in_ch.draw_done;
    end
  end

  // Step the timing and register state by one item
  lcdst_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (in_item_r),
    .res   (step_res)
  );

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) out_item_r <= step_res;
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.read_data    = out_item_r.read_data;
  assign out_ch.lcd_mode     = out_item_r.lcd_mode;
  assign out_ch.current_line = out_item_r.current_line;
  assign out_ch.vblank_irq   = out_item_r.vblank_irq;
  assign out_ch.stat_irq     = out_item_r.stat_irq;
  assign out_ch.frame_done   = out_item_r.frame_done;

endmodule

`default_nettype wire

// File: hdl/lcdst_chk.sv
// Port-level checker for the LCD scanline timing and register block, with its bind.
// Uses lcdst_pkg; attaches to lcd_scanline_timing_registers_unit.
`default_nettype none

module lcdst_chk (
  input wire       clk,
  input wire       rst_n,
  input wire       out_valid,
  input wire       out_ready,
  input wire [7:0] read_data,
  input wire [1:0] lcd_mode,
  input wire [7:0] current_line,
  input wire       vblank_irq,
  input wire       stat_irq,
  input wire       frame_done
);
  import lcdst_pkg::*;

  // A stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({read_data, lcd_mode, current_line, vblank_irq, stat_irq, frame_done}))
    else $error("result item changed while stalled");

  // Line counter stays within the frame
  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> current_line <= LAST_LINE)
    else $error("line beyond last line");

  // Vblank pulse only on entry to the first blank line
  a_vbl_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && vblank_irq |->
      lcd_mode == MODE_VBLANK && current_line == VBLANK_LINE && !frame_done)
    else $error("vblank pulse outside vblank entry");

  // Frame end restarts at line zero in OAM scan
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_done |-> lcd_mode == MODE_OAM && current_line == 8'd0)
    else $error("frame end without wrap to line zero");

endmodule

bind lcd_scanline_timing_registers_unit lcdst_chk u_lcdst_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .read_data    (out_ch.read_data),
  .lcd_mode     (out_ch.lcd_mode),
  .current_line (out_ch.current_line),
  .vblank_irq   (out_ch.vblank_irq),
  .stat_irq     (out_ch.stat_irq),
  .frame_done   (out_ch.frame_done)
);

`default_nettype wire

// File: dv/tb_lcd_scanline_timing_registers_unit.sv
// Self-checking testbench for lcd_scanline_timing_registers_unit.
// Depends on lcdst_pkg, lcdst_in_if, lcdst_out_if and the block's RTL; a built-in
// predictor of dot timing and the register page checks every result item.
`timescale 1ns / 1ps

module tb_lcd_scanline_timing_registers_unit;
  import lcdst_pkg::*;

  // Request code the block must treat as a no-op
  localparam logic [1:0] REQ_UNUSED   = 2'd3;
  localparam int unsigned HANG_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS = 370;

  logic clk;
  logic rst_n;

  lcdst_in_if  in_ch ();
  lcdst_out_if out_ch ();

  lcd_scanline_timing_registers_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predicted timing state and register page, at reset values
  // ---------------------------------------------------------------------------
  logic [8:0] dot_ctr    = '0;
  logic [7:0] line_ctr   = '0;
  mode_t      mode_now   = MODE_HBLANK;
  logic [7:0] lcdc_q     = '0;
  logic [4:0] sel_q      = '0;
  logic       coinc_q    = 1'b0;
  logic [7:0] scy_q      = '0;
  logic [7:0] scx_q      = '0;
  logic [7:0] lyc_q      = '0;
  logic [7:0] dma_q      = '0;
  logic [7:0] pal_q [3]  = '{default: '0};
  logic [7:0] win_q [2]  = '{default: '0};
  logic       lcd_off_q  = 1'b1;
  logic       warm_q     = 1'b0;
  logic [6:0] warm_ctr   = '0;
  logic [2:0] shorten_q  = '0;

  out_item_t results_due [$];

  int unsigned mismatches  = 0;
  int unsigned n_ticks = 0, n_reads = 0, n_writes = 0, n_other = 0;
  int unsigned seen_vbl = 0, seen_stat = 0, seen_frames = 0;

  // Stall phases: while quiet is set, neither side inserts gaps
  bit          quiet = 1'b0;
  logic [7:0]  phase_ctr = '0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;

  // Compare the line with the compare register; update the flag and return
  // the gated interrupt.
  function automatic logic line_hit();
    coinc_q = (lyc_q == line_ctr);
    return coinc_q & sel_q[SEL_LINE_BIT];
  endfunction

  // Advance the predicted state by one item and return the result it causes
  function automatic out_item_t step_timing(input in_item_t it);
    out_item_t r;
    r.read_data  = UNMAPPED_DATA;
    r.vblank_irq = 1'b0;
    r.stat_irq   = 1'b0;
    r.frame_done = 1'b0;
    case (it.req_type)
      REQ_TICK: begin
        // Drop dot ticks entirely while the display is off
        if (!lcd_off_q) begin
          dot_ctr = dot_ctr + 9'd1;
          if (warm_q) begin
            warm_ctr = warm_ctr + 7'd1;
            if (warm_ctr == WARMUP_DOTS) begin
              warm_q    = 1'b0;
              mode_now  = MODE_DRAW;
              shorten_q = SHORTEN_AMOUNT;
            end
          end else begin
            case (mode_now)
              MODE_VBLANK: begin
                if (dot_ctr == DOTS_PER_LINE) begin
                  dot_ctr = '0;
                  if (line_ctr >= LAST_LINE) begin
                    line_ctr     = '0;
                    mode_now     = MODE_OAM;
                    r.frame_done = 1'b1;
                  end else begin
                    line_ctr   = line_ctr + 8'd1;
                    r.stat_irq = line_hit();
                  end
                end
              end
              MODE_OAM: begin
                if (dot_ctr == SCAN_DOTS) mode_now = MODE_DRAW;
              end
              MODE_DRAW: begin
                if (it.draw_done) mode_now = MODE_HBLANK;
              end
              default: begin
                // H-blank ends on an exact match, so a wrapped counter goes round again
                if (dot_ctr == DOTS_PER_LINE - {6'd0, shorten_q}) begin
                  shorten_q  = '0;
                  dot_ctr    = '0;
                  line_ctr   = line_ctr + 8'd1;
                  r.stat_irq = line_hit();
                  if (line_ctr == VBLANK_LINE) begin
                    mode_now     = MODE_VBLANK;
                    r.vblank_irq = 1'b1;
                  end else begin
                    mode_now = MODE_OAM;
                  end
                end
              end
            endcase
          end
        end
      end
      REQ_READ: begin
        case (it.reg_addr)
          ADDR_CTRL: r.read_data = lcdc_q;
          ADDR_STAT: r.read_data = {sel_q, coinc_q, mode_now};
          ADDR_SCY:  r.read_data = scy_q;
          ADDR_SCX:  r.read_data = scx_q;
          ADDR_LINE: r.read_data = line_ctr;
          ADDR_CMP:  r.read_data = lyc_q;
          ADDR_DMA:  r.read_data = dma_q;
          ADDR_PAL0: r.read_data = pal_q[0];
          ADDR_PAL1: r.read_data = pal_q[1];
          ADDR_PAL2: r.read_data = pal_q[2];
          ADDR_WIN0: r.read_data = win_q[0];
          ADDR_WIN1: r.read_data = win_q[1];
          default:   r.read_data = UNMAPPED_DATA;
        endcase
      end
      REQ_WRITE: begin
        case (it.reg_addr)
          ADDR_CTRL: begin
            if (!lcdc_q[CTRL_ON_BIT] && it.write_data[CTRL_ON_BIT]) begin
              warm_q    = 1'b1;
              lcd_off_q = 1'b0;
              warm_ctr  = '0;
              mode_now  = MODE_HBLANK;
            end
            if (lcdc_q[CTRL_ON_BIT] && !it.write_data[CTRL_ON_BIT]) begin
              lcd_off_q = 1'b1;
              line_ctr  = '0;
              dot_ctr   = '0;
            end
            lcdc_q = it.write_data;
          end
          ADDR_STAT: sel_q = it.write_data[7:3];
          ADDR_SCY:  scy_q = it.write_data;
          ADDR_SCX:  scx_q = it.write_data;
          ADDR_CMP: begin
            lyc_q      = it.write_data;
            r.stat_irq = line_hit();
          end
          ADDR_DMA:  dma_q    = it.write_data;
          ADDR_PAL0: pal_q[0] = it.write_data;
          ADDR_PAL1: pal_q[1] = it.write_data;
          ADDR_PAL2: pal_q[2] = it.write_data;
          ADDR_WIN0: win_q[0] = it.write_data;
          ADDR_WIN1: win_q[1] = it.write_data;
          default: ;
        endcase
      end
      default: ;
    endcase
    r.lcd_mode     = mode_now;
    r.current_line = line_ctr;
    return r;
  endfunction

  // Mostly no gap, some short ones, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic in_item_t make_item(input logic [1:0] req, input logic [7:0] a,
                                         input logic [7:0] d, input logic dn);
    in_item_t it;
    it.req_type   = req;
    it.reg_addr   = a;
    it.write_data = d;
    it.draw_done  = dn;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: hold valid until the item is taken, then predict its result.
  // Valid stays high between back-to-back items and drops only for a gap.
  // ---------------------------------------------------------------------------
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    out_item_t   want;
    gap = quiet ? 0 : pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= it.req_type;
    in_ch.reg_addr   <= it.reg_addr;
    in_ch.write_data <= it.write_data;
    in_ch.draw_done  <= it.draw_done;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    want = step_timing(it);
    results_due.push_back(want);
    case (it.req_type)
      REQ_TICK:  n_ticks++;
      REQ_READ:  n_reads++;
      REQ_WRITE: n_writes++;
      default:   n_other++;
    endcase
  endtask

  // Unused fields carry random noise so every input bit toggles
  task automatic tick_dot(input logic dn);
    send_item(make_item(REQ_TICK, 8'($urandom), 8'($urandom), dn));
  endtask

  task automatic read_reg(input logic [7:0] a);
    send_item(make_item(REQ_READ, a, 8'($urandom), 1'($urandom_range(0, 1))));
  endtask

  task automatic write_reg(input logic [7:0] a, input logic [7:0] d);
    send_item(make_item(REQ_WRITE, a, d, 1'($urandom_range(0, 1))));
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, quiet stretches every so often
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    phase_ctr <= phase_ctr + 8'd1;
    if (phase_ctr == 8'd0) quiet <= ($urandom_range(0, 3) == 0);
    if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (!quiet) stall_left <= pick_gap();
    end
  end

  // Check each accepted result against the oldest prediction
  always @(posedge clk) begin : check_results
    out_item_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.read_data    = out_ch.read_data;
      got.lcd_mode     = out_ch.lcd_mode;
      got.current_line = out_ch.current_line;
      got.vblank_irq   = out_ch.vblank_irq;
      got.stat_irq     = out_ch.stat_irq;
      got.frame_done   = out_ch.frame_done;
      seen_vbl    += got.vblank_irq;
      seen_stat   += got.stat_irq;
      seen_frames += got.frame_done;
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result item with none expected", $time);
      end else begin
        want = results_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: want rd=%02h mode=%0d line=%0d vbl=%b stat=%b frm=%b", $time,
                     want.read_data, want.lcd_mode, want.current_line,
                     want.vblank_irq, want.stat_irq, want.frame_done);
            $display("%0t: got  rd=%02h mode=%0d line=%0d vbl=%b stat=%b frm=%b", $time,
                     got.read_data, got.lcd_mode, got.current_line,
                     got.vblank_irq, got.stat_irq, got.frame_done);
          end
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == HANG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", HANG_LIMIT);
      $display("tb_lcd_scanline_timing_registers_unit failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Read the whole page at reset, unmapped ends, the unused request and a dot
  // tick while the display is still off.
  task automatic check_idle_register_map();
    logic [7:0] a;
    for (a = ADDR_CTRL; a <= ADDR_WIN1; a++) read_reg(a);
    read_reg(8'h00);
    read_reg(8'hFF);
    send_item(make_item(REQ_UNUSED, ADDR_CTRL, 8'hFF, 1'b1));
    tick_dot(1'b1);
  endtask

  // Write all ones everywhere but control, including the read-only line
  // register; then an unmapped write and a compare hit while the display is off.
  task automatic check_register_writes();
    logic [7:0] a;
    for (a = ADDR_STAT; a <= ADDR_WIN1; a++) write_reg(a, 8'hFF);
    write_reg(8'h00, 8'h5A);
    write_reg(ADDR_CMP, 8'h00);
    read_reg(ADDR_STAT);
  endtask

  // Enable and run out the warm-up; then disable, tick while off, and enable
  // again so that the next h-blank is shortened.
  task automatic check_enable_warmup();
    write_reg(ADDR_CTRL, 8'hFF);
    repeat (80) tick_dot(1'b0);
    read_reg(ADDR_STAT);
    write_reg(ADDR_CTRL, 8'h00);
    tick_dot(1'b1);
    read_reg(ADDR_LINE);
    write_reg(ADDR_CTRL, 8'h80);
    repeat (90) tick_dot(1'b0);
  endtask

  // Hold drawing past the counter wrap, then let the shortened h-blank find
  // its end dot
  task automatic check_long_drawing();
    logic [7:0] start_line;
    while (mode_now != MODE_DRAW) tick_dot(1'b0);
    repeat (430) tick_dot(1'b0);
    tick_dot(1'b1);
    start_line = line_ctr;
    while (line_ctr == start_line) tick_dot(1'b0);
  endtask

  // Mixed traffic: mostly dot ticks, register traffic around them, compare
  // writes aimed at the current line, rare display toggles and no-op requests.
  task automatic check_random_traffic();
    int unsigned r, k;
    logic [7:0]  a, d;
    if (lcd_off_q) write_reg(ADDR_CTRL, 8'h80 | 8'($urandom_range(0, 127)));
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = $urandom_range(0, 999);
      if (r < 680) begin
        tick_dot($urandom_range(0, 5) == 0);
      end else if (r < 820) begin
        a = ($urandom_range(0, 4) == 0) ? 8'($urandom) : ADDR_CTRL + 8'($urandom_range(0, 11));
        read_reg(a);
      end else if (r < 975) begin
        k = $urandom_range(0, 9);
        d = 8'($urandom);
        if (k == 0) begin
          a = 8'($urandom);
        end else if (k < 4) begin
          a = ADDR_CMP;
          if ($urandom_range(0, 1)) d = line_ctr + 8'($urandom_range(0, 1));
        end else begin
          a = ADDR_STAT + 8'($urandom_range(0, 10));
        end
        write_reg(a, d);
      end else if (r < 990) begin
        // Flip the enable bit on a quarter of control writes
        d = 8'($urandom);
        d[CTRL_ON_BIT] = lcdc_q[CTRL_ON_BIT] ^ ($urandom_range(0, 3) == 0);
        write_reg(ADDR_CTRL, d);
      end else begin
        send_item(make_item(REQ_UNUSED, 8'($urandom), 8'($urandom),
                            1'($urandom_range(0, 1))));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.req_type   <= REQ_TICK;
    in_ch.reg_addr   <= '0;
    in_ch.write_data <= '0;
    in_ch.draw_done  <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    check_idle_register_map();
    check_register_writes();
    check_enable_warmup();
    check_long_drawing();
    check_random_traffic();

    // Stop sending, let every predicted result drain, then let the pipeline run on
    // to show any stray item
    in_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d dot ticks, %0d reads, %0d writes and %0d no-op requests.",
             n_ticks, n_reads, n_writes, n_other);
    $display("Observed %0d frame ends, %0d v-blank and %0d line-compare interrupts.",
             seen_frames, seen_vbl, seen_stat);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("tb_lcd_scanline_timing_registers_unit passed");
    end else begin
      $display("%0d mismatches, %0d results still expected", mismatches, results_due.size());
      $display("tb_lcd_scanline_timing_registers_unit failed");
    end
    $finish;
  end

endmodule

// File: lcd_scanline_timing_registers_unit.f
hdl/lcdst_pkg.sv
hdl/lcdst_if.sv
hdl/lcdst_core.sv
hdl/lcd_scanline_timing_registers_unit.sv
hdl/lcdst_chk.sv
dv/tb_lcd_scanline_timing_registers_unit.sv
